FILE: design/caws_pkg.sv
// ----------------------------------------------------------------------------
// caws_pkg
// shared types and constants of the conflict-aware wave scheduler
// ----------------------------------------------------------------------------
package caws_pkg;

	localparam int MAX_TASKS      = 32;
	localparam int RESOURCE_TYPES = 64;
	localparam int TASK_W         = $clog2(MAX_TASKS);
	localparam int CNT_W          = $clog2(MAX_TASKS + 1);

	localparam logic [1:0] CMD_LOAD_TASK = 2'd0;
	localparam logic [1:0] CMD_LOAD_EDGE = 2'd1;
	localparam logic [1:0] CMD_START     = 2'd2;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_BAD_EDGE = 2'd1;
	localparam logic [1:0] STATUS_CYCLE    = 2'd2;
	localparam logic [1:0] STATUS_NO_TASKS = 2'd3;

	localparam logic REG_TASK_COUNT = 1'b0;

	typedef struct packed {
		logic [1:0]                  command;
		logic [4:0]                  task_index;
		logic [RESOURCE_TYPES-1:0]   component_read_mask;
		logic [RESOURCE_TYPES-1:0]   component_write_mask;
		logic [RESOURCE_TYPES-1:0]   external_read_mask;
		logic [RESOURCE_TYPES-1:0]   external_write_mask;
		logic [5:0]                  edge_before;
		logic [5:0]                  edge_after;
	} in_item_t;

	typedef struct packed {
		logic [4:0] scheduled_task;
		logic [4:0] wave_number;
		logic       wave_publishes;
		logic [1:0] status;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic [RESOURCE_TYPES-1:0] comp_read;
		logic [RESOURCE_TYPES-1:0] comp_write;
		logic [RESOURCE_TYPES-1:0] ext_read;
		logic [RESOURCE_TYPES-1:0] ext_write;
	} task_masks_t;

	typedef struct packed {
		logic clear;
		logic admit;
	} acc_ctrl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_COUNT,
		ST_READY_INIT,
		ST_WAVE_INIT,
		ST_READ,
		ST_CHECK,
		ST_WAVE_END,
		ST_EMIT,
		ST_ERROR,
		ST_CLEAR
	} sched_state_t;

endpackage

FILE: design/conflict_aware_wave_scheduler_core.sv
// ----------------------------------------------------------------------------
// conflict_aware_wave_scheduler_core
// task masks and ordering edges are loaded, then a start builds waves by
// levels and emits one error beat, or else every task with its wave, ascending within a wave
// ----------------------------------------------------------------------------
// channel   direction  handshake               payload
// in        sink       in_valid / in_ready     in_data (in_item_t)
// out       source     out_valid / out_ready   out_data (out_item_t)
// cfg       apb slave  psel / penable / pready paddr, pwdata, prdata
//
// in_ready is high only while the sequencer idles, and loads are taken only then
// a start first counts in-degrees, then per wave scans the mask memory,
// then emits by scanning all n tasks once per wave
// the emission scan stalls on a task to emit while the output register holds an untaken beat
// no clearing pass after reset; edges and in-degrees are dropped in the
// clear state at the end of each run
// ----------------------------------------------------------------------------
module conflict_aware_wave_scheduler_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  caws_pkg::in_item_t    in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output caws_pkg::out_item_t   out_data,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	localparam int N = caws_pkg::MAX_TASKS;
	localparam int TW = caws_pkg::TASK_W;
	localparam int CW = caws_pkg::CNT_W;

	caws_pkg::sched_state_t state_q, state_d;

	logic [5:0]     task_count_q;
	logic [CW-1:0]  n_cfg;
	logic [CW-1:0]  n_q;
	logic [N-1:0]   live;
	logic [N-1:0]   adj_q [N];
	logic [CW-1:0]  pend_q [N];
	logic [N-1:0]   ready_q;
	logic [N-1:0]   nxt_q;
	logic [N-1:0]   cwnz_q;
	logic [TW-1:0]  wave_of_q [N];
	logic [N-1:0]   wflag_q;
	logic           edge_err_q;
	logic [1:0]     err_code_q;
	logic [TW-1:0]  i_q;
	logic [TW-1:0]  wave_q;
	logic [TW-1:0]  w_q;
	logic [CW-1:0]  placed_q;
	logic [CW-1:0]  emitted_q;
	logic           wfl_q;
	logic           out_valid_q;
	caws_pkg::out_item_t out_q;

	logic in_fire, cfg_wr, last_i, slot_free, match, out_load;
	logic rd_en, hit;
	logic edge_bad;
	logic [N-1:0] pend_zero;
	caws_pkg::acc_ctrl_t acc_ctrl;
	caws_pkg::task_masks_t wr_masks, rd_masks;

	assign in_fire   = in_valid && in_ready;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign pready    = 1'b1;
	assign prdata    = {26'd0, task_count_q};
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign slot_free = !out_valid_q || out_ready;
	assign last_i    = ({1'b0, i_q} == (n_q - CW'(1)));
	assign match     = (wave_of_q[i_q] == w_q);
	assign out_load  = ((state_q == caws_pkg::ST_EMIT) && match && slot_free)
		|| ((state_q == caws_pkg::ST_ERROR) && slot_free);

	assign n_cfg = (task_count_q > 6'(N)) ? CW'(N) : CW'(task_count_q);

	assign edge_bad = (in_data.edge_before >= 6'(n_cfg)) || (in_data.edge_after >= 6'(n_cfg))
		|| (in_data.edge_before == in_data.edge_after);

	always_comb begin
		for (int j = 0; j < N; j++) begin
			live[j]      = (CW'(j) < n_q);
			pend_zero[j] = (pend_q[j] == '0);
		end
	end

	assign wr_masks = '{
		comp_read:  in_data.component_read_mask,
		comp_write: in_data.component_write_mask,
		ext_read:   in_data.external_read_mask,
		ext_write:  in_data.external_write_mask
	};

	caws_mask_mem u_mask_mem (
		.clk     (clk),
		.wr_en   (in_fire && in_data.command == caws_pkg::CMD_LOAD_TASK),
		.wr_addr (in_data.task_index),
		.wr_data (wr_masks),
		.rd_en   (rd_en),
		.rd_addr (i_q),
		.rd_data (rd_masks)
	);

	caws_conflict_unit u_conflict (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (acc_ctrl),
		.cand   (rd_masks),
		.hit    (hit)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			caws_pkg::ST_IDLE: begin
				if (in_fire && in_data.command == caws_pkg::CMD_START) begin
					if (edge_err_q || n_cfg == '0)
						state_d = caws_pkg::ST_ERROR;
					else
						state_d = caws_pkg::ST_COUNT;
				end
			end
			caws_pkg::ST_COUNT: begin
				if (last_i)
					state_d = caws_pkg::ST_READY_INIT;
			end
			caws_pkg::ST_READY_INIT: state_d = caws_pkg::ST_WAVE_INIT;
			caws_pkg::ST_WAVE_INIT: begin
				if (placed_q == n_q)
					state_d = caws_pkg::ST_EMIT;
				else if (ready_q == '0)
					state_d = caws_pkg::ST_ERROR;
				else
					state_d = caws_pkg::ST_READ;
			end
			caws_pkg::ST_READ: begin
				if (ready_q[i_q])
					state_d = caws_pkg::ST_CHECK;
				else if (last_i)
					state_d = caws_pkg::ST_WAVE_END;
			end
			caws_pkg::ST_CHECK: begin
				state_d = last_i ? caws_pkg::ST_WAVE_END : caws_pkg::ST_READ;
			end
			caws_pkg::ST_WAVE_END: state_d = caws_pkg::ST_WAVE_INIT;
			caws_pkg::ST_EMIT: begin
				if (match && slot_free && (emitted_q + CW'(1) == n_q))
					state_d = caws_pkg::ST_CLEAR;
			end
			caws_pkg::ST_ERROR: begin
				if (slot_free)
					state_d = caws_pkg::ST_CLEAR;
			end
			caws_pkg::ST_CLEAR: state_d = caws_pkg::ST_IDLE;
			default: state_d = caws_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready       = 1'b0;
		rd_en          = 1'b0;
		acc_ctrl.clear = 1'b0;
		acc_ctrl.admit = 1'b0;
		case (state_q)
			caws_pkg::ST_IDLE:      in_ready = 1'b1;
			caws_pkg::ST_WAVE_INIT: acc_ctrl.clear = 1'b1;
			caws_pkg::ST_READ:      rd_en = ready_q[i_q];
			caws_pkg::ST_CHECK:     acc_ctrl.admit = !hit;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= caws_pkg::ST_IDLE;
			task_count_q <= '0;
			n_q          <= '0;
			edge_err_q   <= 1'b0;
			err_code_q   <= caws_pkg::STATUS_OK;
			ready_q      <= '0;
			nxt_q        <= '0;
			i_q          <= '0;
			wave_q       <= '0;
			w_q          <= '0;
			placed_q     <= '0;
			emitted_q    <= '0;
			wfl_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int r = 0; r < N; r++) begin
				adj_q[r]  <= '0;
				pend_q[r] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_wr && paddr[2] == caws_pkg::REG_TASK_COUNT)
				task_count_q <= pwdata[5:0];
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				caws_pkg::ST_IDLE: begin
					if (in_fire && in_data.command == caws_pkg::CMD_LOAD_EDGE) begin
						if (edge_bad)
							edge_err_q <= 1'b1;
						else
							adj_q[in_data.edge_before[TW-1:0]][in_data.edge_after[TW-1:0]]
								<= 1'b1;
					end
					if (in_fire && in_data.command == caws_pkg::CMD_START) begin
						n_q      <= n_cfg;
						i_q      <= '0;
						placed_q <= '0;
						for (int r = 0; r < N; r++)
							pend_q[r] <= '0;
						if (edge_err_q)
							err_code_q <= caws_pkg::STATUS_BAD_EDGE;
						else
							err_code_q <= caws_pkg::STATUS_NO_TASKS;
					end
				end
				caws_pkg::ST_COUNT: begin
					// one adjacency row per cycle into all in-degree counters
					for (int j = 0; j < N; j++)
						pend_q[j] <= pend_q[j] + CW'(adj_q[i_q][j] & live[j]);
					i_q <= i_q + TW'(1);
				end
				caws_pkg::ST_READY_INIT: begin
					ready_q  <= live & pend_zero;
					nxt_q    <= '0;
					placed_q <= '0;
					wave_q   <= '0;
				end
				caws_pkg::ST_WAVE_INIT: begin
					i_q   <= '0;
					wfl_q <= 1'b0;
					w_q   <= '0;
					emitted_q <= '0;
					err_code_q <= caws_pkg::STATUS_CYCLE;
				end
				caws_pkg::ST_READ: begin
					if (!ready_q[i_q] && !last_i)
						i_q <= i_q + TW'(1);
				end
				caws_pkg::ST_CHECK: begin
					if (!hit) begin
						ready_q[i_q] <= 1'b0;
						placed_q     <= placed_q + CW'(1);
						wfl_q        <= wfl_q | cwnz_q[i_q];
						// successors that reach zero become ready for the next wave
						for (int j = 0; j < N; j++) begin
							if (adj_q[i_q][j] && live[j] && !pend_zero[j]) begin
								pend_q[j] <= pend_q[j] - CW'(1);
								if (pend_q[j] == CW'(1))
									nxt_q[j] <= 1'b1;
							end
						end
					end
					if (!last_i)
						i_q <= i_q + TW'(1);
				end
				caws_pkg::ST_WAVE_END: begin
					wave_q  <= wave_q + TW'(1);
					ready_q <= ready_q | nxt_q;
					nxt_q   <= '0;
				end
				caws_pkg::ST_EMIT: begin
					if (!(match && !slot_free)) begin
						if (match)
							emitted_q <= emitted_q + CW'(1);
						if (last_i) begin
							i_q <= '0;
							w_q <= w_q + TW'(1);
						end else begin
							i_q <= i_q + TW'(1);
						end
					end
				end
				caws_pkg::ST_CLEAR: begin
					edge_err_q <= 1'b0;
					ready_q    <= '0;
					for (int r = 0; r < N; r++) begin
						adj_q[r]  <= '0;
						pend_q[r] <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire && in_data.command == caws_pkg::CMD_LOAD_TASK)
			cwnz_q[in_data.task_index] <= (in_data.component_write_mask != '0);
		if (state_q == caws_pkg::ST_CHECK && !hit)
			wave_of_q[i_q] <= wave_q;
		if (state_q == caws_pkg::ST_WAVE_END)
			wflag_q[wave_q] <= wfl_q;
		if (state_q == caws_pkg::ST_EMIT && match && slot_free) begin
			out_q.scheduled_task <= i_q;
			out_q.wave_number    <= w_q;
			out_q.wave_publishes <= wflag_q[w_q];
			out_q.status         <= caws_pkg::STATUS_OK;
			out_q.last           <= (emitted_q + CW'(1) == n_q);
		end
		if (state_q == caws_pkg::ST_ERROR && slot_free) begin
			out_q.scheduled_task <= '0;
			out_q.wave_number    <= '0;
			out_q.wave_publishes <= 1'b0;
			out_q.status         <= err_code_q;
			out_q.last           <= 1'b1;
		end
	end

`ifndef ASSERT_OFF
	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status != caws_pkg::STATUS_OK) |-> out_data.last)
		else $error("error beat without last");

	a_clear_drops_edge_err: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == caws_pkg::ST_CLEAR) |=> !edge_err_q)
		else $error("edge error survives run end");

	a_placed_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != caws_pkg::ST_IDLE) |-> (placed_q <= n_q))
		else $error("more tasks placed than scheduled");
`endif

endmodule

FILE: design/caws_mask_mem.sv
// ----------------------------------------------------------------------------
// caws_mask_mem
// per-task access mask storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module caws_mask_mem (
	input  logic                               clk,
	input  logic                               wr_en,
	input  logic [caws_pkg::TASK_W-1:0]        wr_addr,
	input  caws_pkg::task_masks_t              wr_data,
	input  logic                               rd_en,
	input  logic [caws_pkg::TASK_W-1:0]        rd_addr,
	output caws_pkg::task_masks_t              rd_data
);

	caws_pkg::task_masks_t mem_q [caws_pkg::MAX_TASKS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: design/caws_conflict_unit.sv
// ----------------------------------------------------------------------------
// caws_conflict_unit
// checks one candidate against the access union of the wave taken so far
// ----------------------------------------------------------------------------
module caws_conflict_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  caws_pkg::acc_ctrl_t   ctrl,
	input  caws_pkg::task_masks_t cand,
	output logic                  hit
);

	caws_pkg::task_masks_t acc_q;

	// a shared type conflicts when either side writes it
	assign hit = (((cand.comp_read | cand.comp_write) & acc_q.comp_write) != '0)
		|| ((cand.comp_write & acc_q.comp_read) != '0)
		|| (((cand.ext_read | cand.ext_write) & acc_q.ext_write) != '0)
		|| ((cand.ext_write & acc_q.ext_read) != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.clear) begin
			acc_q <= '0;
		end else if (ctrl.admit) begin
			acc_q.comp_read  <= acc_q.comp_read | cand.comp_read;
			acc_q.comp_write <= acc_q.comp_write | cand.comp_write;
			acc_q.ext_read   <= acc_q.ext_read | cand.ext_read;
			acc_q.ext_write  <= acc_q.ext_write | cand.ext_write;
		end
	end

endmodule
